@@ rtl/core/eth_tx_pkg.sv @@
// Shared constants, types and functions of the 10BASE-T transmit framer.
package eth_tx_pkg;

  localparam int MAX_FRAME_BYTES = 1518;
  localparam int MIN_FRAME_BYTES = 60;
  localparam int COUNT_W         = 11;
  localparam int REPS_W          = 6;
  localparam int WORD_W          = 32;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_FRAME_BYTES);
  localparam logic [COUNT_W-1:0] MIN_COUNT   = COUNT_W'(MIN_FRAME_BYTES);
  localparam logic [7:0]         PRE_BYTE    = 8'h55;
  localparam logic [7:0]         SFD_BYTE    = 8'hD5;
  localparam logic [REPS_W-1:0]  PRE_REPS    = 6'd7;
  localparam logic [WORD_W-1:0]  IDLE_WORD   = 32'h0000_0AAA;
  localparam logic [31:0]        CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0]        CRC_POLY    = 32'hEDB8_8320;

  typedef enum logic [2:0] {
    W_PRE  = 3'd0,
    W_SFD  = 3'd1,
    W_DATA = 3'd2,
    W_PAD  = 3'd3,
    W_FCS  = 3'd4,
    W_IDLE = 3'd5
  } word_sel_t;

  typedef struct packed {
    logic      take;
    logic      emit;
    word_sel_t sel;
    logic      emit_last;
    logic      frame_open;
    logic      crc_data;
    logic      crc_pad;
    logic      fcs_adv;
    logic      frame_close;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic drop;
    logic short_frame;
    logic fcs_last;
    logic out_free;
    logic last;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] manchester(input logic [7:0] b);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[4*i +: 4] = b[i] ? 4'h9 : 4'h6;
    end
    return w;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ethernet_10baset_tx_framer_unit.sv @@
// Top level of the 10BASE-T Manchester transmit framer.
// Each in-frame byte is held on accept and its line word is registered once the output is free.
// The first byte of a frame is preceded by the preamble and SFD words.
// A final byte is followed by a pad word when short (one CRC step per pad byte, up to
// 59), then four FCS words and an idle word. A new byte is taken only in the idle state.
// Synchronous reset closes any open frame and empties the output register.
module ethernet_10baset_tx_framer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [eth_tx_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [31:0] line_word, [37:32] repeat_count
  output logic                                m_tlast
);

  eth_tx_pkg::ctrl_cmd_t  cmd;
  eth_tx_pkg::dp_status_t status;

  eth_tx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eth_tx_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/core/eth_tx_dp.sv @@
// Datapath of the transmit framer: byte hold, counters, CRC and output register.
module eth_tx_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  eth_tx_pkg::ctrl_cmd_t                cmd,
  output eth_tx_pkg::dp_status_t               status,
  input  logic [7:0]                           in_byte,
  input  logic                                 in_last,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [eth_tx_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                 m_tlast
);

  logic                               in_frame;
  logic [eth_tx_pkg::COUNT_W-1:0]     byte_count;
  logic [31:0]                        crc;
  logic [7:0]                         data_reg;
  logic                               last_reg;
  logic [1:0]                         fcs_idx;
  logic [31:0]                        fcs;
  logic [eth_tx_pkg::WORD_W-1:0]      word_next;
  logic [eth_tx_pkg::REPS_W-1:0]      reps_next;
  logic [eth_tx_pkg::COUNT_W-1:0]     pad_span;

  assign fcs      = ~crc;
  assign pad_span = eth_tx_pkg::MIN_COUNT - byte_count;

  always_comb begin
    word_next = eth_tx_pkg::IDLE_WORD;
    reps_next = eth_tx_pkg::REPS_W'(1);
    unique case (cmd.sel)
      eth_tx_pkg::W_PRE: begin
        word_next = eth_tx_pkg::manchester(eth_tx_pkg::PRE_BYTE);
        reps_next = eth_tx_pkg::PRE_REPS;
      end
      eth_tx_pkg::W_SFD:  word_next = eth_tx_pkg::manchester(eth_tx_pkg::SFD_BYTE);
      eth_tx_pkg::W_DATA: word_next = eth_tx_pkg::manchester(data_reg);
      eth_tx_pkg::W_PAD: begin
        word_next = eth_tx_pkg::manchester(8'h00);
        reps_next = pad_span[eth_tx_pkg::REPS_W-1:0];
      end
      eth_tx_pkg::W_FCS:  word_next = eth_tx_pkg::manchester(fcs[8*fcs_idx +: 8]);
      eth_tx_pkg::W_IDLE: word_next = eth_tx_pkg::IDLE_WORD;
      default:            word_next = eth_tx_pkg::IDLE_WORD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_reg <= in_byte;
      last_reg <= in_last;
    end
    if (cmd.emit) begin
      m_tdata <= {2'b00, reps_next, word_next};
      m_tlast <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
      crc        <= eth_tx_pkg::CRC_INIT;
      fcs_idx    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.frame_close) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
        crc        <= eth_tx_pkg::CRC_INIT;
        fcs_idx    <= '0;
      end else if (cmd.frame_open) begin
        in_frame   <= 1'b1;
        byte_count <= '0;
        crc        <= eth_tx_pkg::CRC_INIT;
        fcs_idx    <= '0;
      end else if (cmd.crc_data) begin
        crc        <= eth_tx_pkg::crc_byte(crc, data_reg);
        byte_count <= byte_count + 1'b1;
      end else if (cmd.crc_pad) begin
        crc        <= eth_tx_pkg::crc_byte(crc, 8'h00);
        byte_count <= byte_count + 1'b1;
      end else if (cmd.fcs_adv) begin
        fcs_idx    <= fcs_idx + 1'b1;
      end
    end
  end

  assign status.in_frame    = in_frame;
  assign status.drop        = (byte_count >= eth_tx_pkg::MAX_COUNT);
  assign status.short_frame = (byte_count < eth_tx_pkg::MIN_COUNT);
  assign status.fcs_last    = (fcs_idx == 2'd3);
  assign status.out_free    = !m_tvalid || m_tready;
  assign status.last        = last_reg;

endmodule

@@ rtl/core/eth_tx_ctrl.sv @@
// Controller state machine of the transmit framer.
module eth_tx_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  eth_tx_pkg::dp_status_t status,
  output eth_tx_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PRE    = 8'b0000_0010,
    S_SFD    = 8'b0000_0100,
    S_DATA   = 8'b0000_1000,
    S_PAD    = 8'b0001_0000,
    S_PADCRC = 8'b0010_0000,
    S_FCS    = 8'b0100_0000,
    S_TAIL   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = eth_tx_pkg::W_IDLE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = status.in_frame ? S_DATA : S_PRE;
        end
      end
      S_PRE: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.sel        = eth_tx_pkg::W_PRE;
          cmd.frame_open = 1'b1;
          state_next     = S_SFD;
        end
      end
      S_SFD: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = eth_tx_pkg::W_SFD;
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (status.drop) begin
          state_next = status.last ? S_PAD : S_IDLE;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = eth_tx_pkg::W_DATA;
          cmd.emit_last = !status.last;
          cmd.crc_data  = 1'b1;
          state_next    = status.last ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        if (!status.short_frame) begin
          state_next = S_FCS;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = eth_tx_pkg::W_PAD;
          state_next = S_PADCRC;
        end
      end
      S_PADCRC: begin
        if (status.short_frame) begin
          cmd.crc_pad = 1'b1;
        end else begin
          state_next = S_FCS;
        end
      end
      S_FCS: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = eth_tx_pkg::W_FCS;
          cmd.fcs_adv = 1'b1;
          if (status.fcs_last) begin
            state_next = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.sel         = eth_tx_pkg::W_IDLE;
          cmd.emit_last   = 1'b1;
          cmd.frame_close = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/eth_tx_chk.sv @@
// Port checker of the transmit framer and its bind to the top level.
module eth_tx_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_reps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:32] != 6'd0)
    else $error("zero repeat count");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == 32'h0000_0AAA |-> m_tlast && m_tdata[37:32] == 6'd1)
    else $error("idle word not closing the run");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind ethernet_10baset_tx_framer_unit eth_tx_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/sv/tb_ethernet_10baset_tx_framer_unit.sv @@
// Self-checking testbench of the 10BASE-T transmit framer: random frames, stalls, line word check.
module tb_ethernet_10baset_tx_framer_unit;

  localparam int RAND_BYTES  = 320;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       lst;
    logic       hold;
  } frame_byte_t;

  typedef struct packed {
    logic [eth_tx_pkg::WORD_W-1:0] word;
    logic [eth_tx_pkg::REPS_W-1:0] reps;
    logic                          last;
  } line_beat_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_t;

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata  = '0;
  logic                               s_tlast  = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [eth_tx_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                               m_tlast;

  frame_byte_t tx_bytes[$];
  line_beat_t  line_q[$];
  line_beat_t  want;
  logic        settled = 1'b1;
  int          errors  = 0;
  int          cycles  = 0;

  logic        frame_open;
  int          byte_cnt;
  logic [31:0] crc;

  int          burst_left = 0;
  int          gap_left   = 0;
  rx_mode_t    rx_mode    = RX_STEADY;
  int          phase_left = 0;
  int          comb_cnt   = 0;

  ethernet_10baset_tx_framer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [eth_tx_pkg::WORD_W-1:0] line_code(input logic [7:0] b);
    logic [eth_tx_pkg::WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w = w | ((b[i] ? 32'h9 : 32'h6) << (4 * i));
    end
    return w;
  endfunction

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ eth_tx_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void add_beat(input logic [eth_tx_pkg::WORD_W-1:0] w,
                                   input logic [eth_tx_pkg::REPS_W-1:0] n);
    line_beat_t b;
    b.word = w;
    b.reps = n;
    b.last = 1'b0;
    line_q.push_back(b);
  endfunction

  function automatic void frame_byte(input logic [7:0] d, input logic lst);
    int          first_idx;
    int          pad;
    logic [31:0] fcs;
    first_idx = line_q.size();
    if (!frame_open) begin
      add_beat(line_code(eth_tx_pkg::PRE_BYTE), eth_tx_pkg::PRE_REPS);
      add_beat(line_code(eth_tx_pkg::SFD_BYTE), eth_tx_pkg::REPS_W'(1));
      frame_open = 1'b1;
      byte_cnt   = 0;
      crc        = eth_tx_pkg::CRC_INIT;
    end
    if (byte_cnt < eth_tx_pkg::MAX_FRAME_BYTES) begin
      add_beat(line_code(d), eth_tx_pkg::REPS_W'(1));
      crc      = crc_fold(crc, d);
      byte_cnt = byte_cnt + 1;
    end
    if (lst) begin
      if (byte_cnt < eth_tx_pkg::MIN_FRAME_BYTES) begin
        pad = eth_tx_pkg::MIN_FRAME_BYTES - byte_cnt;
        add_beat(line_code(8'h00), eth_tx_pkg::REPS_W'(pad));
        for (int i = 0; i < pad; i++) begin
          crc = crc_fold(crc, 8'h00);
        end
      end
      fcs = ~crc;
      for (int i = 0; i < 4; i++) begin
        add_beat(line_code(fcs[8*i +: 8]), eth_tx_pkg::REPS_W'(1));
      end
      add_beat(eth_tx_pkg::IDLE_WORD, eth_tx_pkg::REPS_W'(1));
      frame_open = 1'b0;
      byte_cnt   = 0;
      crc        = eth_tx_pkg::CRC_INIT;
    end
    if (line_q.size() > first_idx) begin
      line_q[line_q.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void log_error(input string msg);
    errors = errors + 1;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] d, input logic lst, input logic hold);
    frame_byte_t fb;
    fb.data = d;
    fb.lst  = lst;
    fb.hold = hold;
    tx_bytes.push_back(fb);
  endfunction

  function automatic void queue_frame(input int len, input logic hold_first);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom), i == len - 1, hold_first && i == 0);
    end
  endfunction

  // sender: bursts with random gaps, hold-off until drained on marked bytes
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        void'(tx_bytes.pop_front());
      end
      if (s_tvalid && !s_tready) begin
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (tx_bytes.size() == 0 || (tx_bytes[0].hold && (s_tvalid || !settled))) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= tx_bytes[0].data;
        s_tlast  <= tx_bytes[0].lst;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern switches at random between steady, coin-flip, comb and trickle modes
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left = phase_left - 1;
      end
      comb_cnt = (comb_cnt + 1) % 5;
      case (rx_mode)
        RX_STEADY:  m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_COMB:    m_tready <= (comb_cnt != 0);
        default:    m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: check output beats, predict on accepted input beats
  always @(posedge clk) begin
    if (rst) begin
      frame_open = 1'b0;
      byte_cnt   = 0;
      crc        = eth_tx_pkg::CRC_INIT;
      settled <= 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (line_q.size() == 0) begin
          log_error($sformatf("unexpected beat word=%h reps=%0d last=%b",
                              m_tdata[eth_tx_pkg::WORD_W-1:0],
                              m_tdata[eth_tx_pkg::WORD_W +: eth_tx_pkg::REPS_W], m_tlast));
        end else begin
          want = line_q.pop_front();
          if (m_tdata[eth_tx_pkg::WORD_W-1:0] !== want.word ||
              m_tdata[eth_tx_pkg::WORD_W +: eth_tx_pkg::REPS_W] !== want.reps ||
              m_tlast !== want.last) begin
            log_error($sformatf("mismatch exp word=%h reps=%0d last=%b got word=%h reps=%0d last=%b",
                                want.word, want.reps, want.last,
                                m_tdata[eth_tx_pkg::WORD_W-1:0],
                                m_tdata[eth_tx_pkg::WORD_W +: eth_tx_pkg::REPS_W], m_tlast));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        frame_byte(s_tdata, s_tlast);
      end
      settled <= (line_q.size() == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int         sent;
    int         len;
    line_beat_t miss;
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h55, 1'b0, 1'b0);
    queue_byte(8'hAA, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'hD5, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b1, 1'b0);
    queue_frame(eth_tx_pkg::MIN_FRAME_BYTES, 1'b0);
    queue_frame(eth_tx_pkg::MIN_FRAME_BYTES - 1, 1'b1);
    sent = 0;
    while (sent < RAND_BYTES) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(eth_tx_pkg::MIN_FRAME_BYTES - 1,
                                      eth_tx_pkg::MIN_FRAME_BYTES + 1);
        1:       len = $urandom_range(eth_tx_pkg::MIN_FRAME_BYTES + 2, 100);
        default: len = $urandom_range(1, eth_tx_pkg::MIN_FRAME_BYTES - 2);
      endcase
      queue_frame(len, $urandom_range(0, 3) == 0);
      sent = sent + len;
    end
    queue_frame($urandom_range(1, 20), 1'b1);
    queue_frame($urandom_range(1, 70), 1'b0);

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (tx_bytes.size() != 0 || s_tvalid || !settled);
    repeat (TAIL_CYCLES) @(negedge clk);
    while (line_q.size() != 0) begin
      miss = line_q.pop_front();
      log_error($sformatf("missing beat word=%h reps=%0d last=%b", miss.word, miss.reps, miss.last));
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
